@@ src/assert_macros.svh @@
// assertion macros used by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assert");
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

@@ src/psvm_pkg.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// psvm_pkg
// types and constants of the sample voice mixer
// ------------------------------------------------------------------------
package psvm_pkg;
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_PLAY = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;
  localparam logic [1:0] REQ_INFO = 2'd3;
  localparam logic [0:0] REG_MASTER = 1'b0;
  localparam logic [0:0] REG_CHANNELS = 1'b1;
  localparam logic signed [47:0] OUT_MAX = 48'sd8388607;
  localparam logic signed [47:0] OUT_MIN = -48'sd8388608;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL1, ST_MUL2, ST_ACC, ST_OUT
  } state_e;
endpackage

@@ src/polyphonic_sample_voice_mixer_unit.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// polyphonic_sample_voice_mixer_unit
// one-shot sample voices mixed into a saturated stereo frame
// ------------------------------------------------------------------------
// usage:
//  - requests come in on the req channel (valid/ready); a tick request
//    returns one frame on the out channel, the others return nothing
//  - play, load and info requests are carried out when accepted, in idle
//  - a tick walks the voices one at a time, each visit going through
//    read (voice record and sample memory read), two multiplies and
//    accumulate, then a saturate state loads the output register; the
//    shared multiplier chain and the single sample memory read port make
//    the voices go one at a time
//  - a new tick is accepted only once the block is back in idle and the
//    last frame has been taken
//  - the frame waits in an output register; while it is not taken the
//    block keeps accepting non-tick requests, the next tick waits
//  - reset frees every voice, empties the sound table and restores the
//    registers; the sample memory is not cleared (read only once written)
//  - voice records sit in a ram, read on each voice visit and written back for a live voice
//  - apb writes take effect at once; write only while no tick is in flight
// ------------------------------------------------------------------------
module polyphonic_sample_voice_mixer_unit
  import psvm_pkg::*;
#(
  parameter int NUM_VOICES  = 8,
  parameter int NUM_SOUNDS  = 5,
  parameter int MAX_SAMPLES = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         sound_id_i,
  input  logic [15:0]        gain_i,
  input  logic signed [15:0] pan_i,
  input  logic [0:0]         channel_i,
  input  logic [13:0]        sample_index_i,
  input  logic signed [15:0] sample_value_i,
  input  logic [14:0]        sound_length_i,
  input  logic [1:0]         sound_channels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] left_out_o,
  output logic signed [23:0] right_out_o,
  output logic               clipped_o
);
  `include "assert_macros.svh"

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam int PW = $clog2(MAX_SAMPLES);
  localparam int LW = PW + 1;
  localparam int MD = NUM_SOUNDS * 2 * MAX_SAMPLES;
  localparam int MW = $clog2(MD);
  // voice record: sound, position, gain, pan
  localparam int RW = SW + PW + 32;

  // configuration registers
  logic [15:0] master_q;
  logic [1:0]  chans_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= 16'd32768;
      chans_q  <= 2'd2;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_MASTER) master_q <= pwdata[15:0];
      else                        chans_q  <= pwdata[1:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_MASTER) prdata = {16'd0, master_q};
      else                        prdata = {30'd0, chans_q};
    end
  end

  // sound table and voice activity flags
  logic [LW-1:0] len_q [NUM_SOUNDS];
  logic [1:0]    sch_q [NUM_SOUNDS];
  logic [NUM_VOICES-1:0] act_q;

  state_e state_q, state_d;
  logic [VW-1:0] vidx_q;
  logic          acc;
  logic          snd_ok;
  assign acc    = req_valid_i && req_ready_o;
  assign snd_ok = 32'(sound_id_i) < NUM_SOUNDS;
  assign req_ready_o = (state_q == ST_IDLE) &&
                       !(req_type_i == REQ_TICK && out_valid_o);

  // first idle voice
  logic [VW-1:0] free_idx;
  logic          free_any;
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!act_q[v]) begin
        free_idx = VW'(v);
        free_any = 1'b1;
      end
    end
  end

  logic [SW-1:0] sid;
  assign sid = sound_id_i[SW-1:0];
  logic play_go;
  assign play_go = acc && req_type_i == REQ_PLAY && snd_ok && free_any &&
                   len_q[sid] != '0;

  // voice record ram
  logic          vwe;
  logic [VW-1:0] vwaddr, vraddr;
  logic [RW-1:0] vwdata, vrdata;
  psvm_ram #(.Width(RW), .Depth(1 << VW)) u_voice (
    .clk_i, .we_i(vwe), .waddr_i(vwaddr), .wdata_i(vwdata),
    .raddr_i(vraddr), .rdata_o(vrdata)
  );

  // sample ram
  logic          swe;
  logic [MW-1:0] swaddr, sraddr;
  logic [15:0]   srdata;
  psvm_ram #(.Width(16), .Depth(MD)) u_smp (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(sample_value_i),
    .raddr_i(sraddr), .rdata_o(srdata)
  );
  assign swe = acc && req_type_i == REQ_LOAD && snd_ok &&
               32'(sample_index_i) < MAX_SAMPLES;
  assign swaddr = MW'((32'(sid) * 2 + 32'(channel_i)) * MAX_SAMPLES +
                      32'(sample_index_i));

  // fields of the voice record being visited
  logic [SW-1:0] r_snd;
  logic [PW-1:0] r_pos;
  logic [15:0]   r_gain;
  logic signed [15:0] r_pan;
  assign {r_snd, r_pos, r_gain, r_pan} = vrdata;
  logic [SW-1:0] s_eff;
  assign s_eff = (32'(r_snd) < NUM_SOUNDS) ? r_snd : '0;

  // per-visit registers
  logic               live_q;  // voice active and inside its sound
  logic [SW-1:0]      snd_q;
  logic [PW-1:0]      pos_q;
  logic [15:0]        gain_q;
  logic signed [15:0] pan_q;
  logic               rch_q;
  logic [31:0]        base_q;
  logic [16:0]        wl_q, wr_q;
  logic signed [15:0] sl_q;
  logic signed [49:0] cl_q, cr_q;   // base*weight, fits below 2^49
  logic signed [66:0] tl_q, tr_q;
  logic signed [47:0] lsum_q, rsum_q;
  logic               rsel_q;       // second sample read pending
  logic               last_q;

  // next position and retire
  logic [LW-1:0] npos;
  logic          ndone;
  assign npos  = LW'(pos_q) + LW'(1);
  assign ndone = npos >= len_q[snd_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc && req_type_i == REQ_TICK) state_d = ST_RD;
      ST_RD:   state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_OUT : ST_RD;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    vwe    = 1'b0;
    vwaddr = vidx_q;
    vwdata = {snd_q, ndone ? PW'(0) : npos[PW-1:0], gain_q, pan_q};
    // fetch the next record while the current one is written back
    vraddr = vidx_q;
    if (state_q == ST_IDLE)     vraddr = '0;
    else if (state_q == ST_ACC) vraddr = vidx_q + VW'(1);
    if (play_go) begin
      vwe    = 1'b1;
      vwaddr = free_idx;
      vwdata = {sid, PW'(0), gain_i, pan_i};
    end else if (state_q == ST_ACC && live_q) begin
      vwe = 1'b1;
    end
  end
  // first read takes channel 0 straight from the arriving record,
  // second the right-side channel from the registered copy
  assign sraddr = (state_q == ST_RD)
                ? MW'(32'(s_eff) * 2 * MAX_SAMPLES + 32'(r_pos))
                : MW'((32'(snd_q) * 2 + (rsel_q ? 32'(rch_q) : 0)) *
                      MAX_SAMPLES + 32'(pos_q));

  logic signed [47:0] lt, rt;
  logic signed [66:0] rl, rr;
  assign rl = (tl_q + (67'sd1 <<< 44)) >>> 45;
  assign rr = (tr_q + (67'sd1 <<< 44)) >>> 45;
  assign lt = rl[47:0];
  assign rt = rr[47:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= '0;
      vidx_q  <= '0;
      live_q  <= 1'b0;
      rsel_q  <= 1'b0;
      last_q  <= 1'b0;
      for (int s = 0; s < NUM_SOUNDS; s++) begin
        len_q[s] <= '0;
        sch_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (play_go) act_q[free_idx] <= 1'b1;
      if (acc && req_type_i == REQ_INFO && snd_ok) begin
        len_q[sid] <= (32'(sound_length_i) > MAX_SAMPLES) ? LW'(MAX_SAMPLES)
                                                           : LW'(sound_length_i);
        sch_q[sid] <= sound_channels_i;
      end
      case (state_q)
        ST_IDLE: vidx_q <= '0;
        ST_RD: begin
          // record has arrived; check against the sound length
          live_q <= act_q[vidx_q] && LW'(r_pos) < len_q[s_eff];
          if (act_q[vidx_q] && !(LW'(r_pos) < len_q[s_eff]))
            act_q[vidx_q] <= 1'b0;
          rsel_q <= 1'b1;
          last_q <= 32'(vidx_q) == NUM_VOICES - 1;
        end
        ST_MUL1: rsel_q <= 1'b0;
        ST_ACC: begin
          if (live_q && ndone) act_q[vidx_q] <= 1'b0;
          vidx_q <= vidx_q + VW'(1);
          live_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        lsum_q <= '0;
        rsum_q <= '0;
      end
      ST_RD: begin
        snd_q  <= s_eff;
        pos_q  <= r_pos;
        gain_q <= r_gain;
        pan_q  <= r_pan;
        rch_q  <= sch_q[s_eff] >= 2'd2;
        base_q <= 32'(r_gain) * 32'(master_q);
        wl_q   <= (chans_q >= 2'd2 && r_pan > 0) ? 17'(17'sd32768 - 17'(r_pan))
                                                 : 17'd32768;
        wr_q   <= (chans_q >= 2'd2 && r_pan < 0) ? 17'(17'sd32768 + 17'(r_pan))
                                                 : 17'd32768;
      end
      ST_MUL1: begin
        sl_q <= srdata;
        cl_q <= 50'($signed({1'b0, base_q}) * $signed({1'b0, wl_q}));
        cr_q <= 50'($signed({1'b0, base_q}) * $signed({1'b0, wr_q}));
      end
      ST_MUL2: begin
        tl_q <= 67'(sl_q * cl_q);
        tr_q <= 67'($signed(srdata) * cr_q);
      end
      ST_ACC: begin
        if (live_q && chans_q != 2'd0) begin
          lsum_q <= lsum_q + lt;
          if (chans_q >= 2'd2) rsum_q <= rsum_q + rt;
        end
      end
      default: ;
    endcase
  end

  // output register
  logic cl_hi, cl_lo, cr_hi, cr_lo;
  assign cl_hi = lsum_q > OUT_MAX;
  assign cl_lo = lsum_q < OUT_MIN;
  assign cr_hi = rsum_q > OUT_MAX;
  assign cr_lo = rsum_q < OUT_MIN;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (state_q == ST_OUT) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      left_out_o  <= cl_hi ? 24'sd8388607 : cl_lo ? -24'sd8388608 : lsum_q[23:0];
      right_out_o <= cr_hi ? 24'sd8388607 : cr_lo ? -24'sd8388608 : rsum_q[23:0];
      clipped_o   <= cl_hi | cl_lo | cr_hi | cr_lo;
    end
  end

  `ASSERT_NEVER(a_tick_busy, state_q != ST_IDLE && req_ready_o)
  `ASSERT_IMPL(a_out_after, state_q == ST_OUT |=> out_valid_o)
  `ASSERT_IMPL(a_hold, out_valid_o && !out_ready_i |=> $stable(left_out_o))
  `ASSERT_NEVER(a_two_writes, vwe && play_go && state_q != ST_IDLE)
endmodule

@@ src/psvm_ram.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// psvm_ram
// generic simple dual port ram (one write, one read port) with registered read
// ------------------------------------------------------------------------
module psvm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
